/* hdl/lpfr_pkg.sv */
package lpfr_pkg;

	localparam int FRAME_BUFFER_BYTES_DEF = 1024;

	localparam int MAX_PAYLOAD_W = 10;
	localparam int LIMIT_W       = 8;
	localparam int CFG_DATA_W    = 10;
	localparam int CFG_INDEX_W   = 2;
	localparam int POS_W         = 10;
	localparam int LEN_W         = 16;
	localparam int CNT_W         = 8;
	localparam int IN_DATA_W     = 16;
	localparam int OUT_DATA_W    = 64;

	localparam logic [CFG_INDEX_W-1:0] REG_MAX_PAYLOAD       = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RX_ERROR_LIMIT    = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PARSE_ERROR_LIMIT = 2'd2;

	localparam logic [MAX_PAYLOAD_W-1:0] MAX_PAYLOAD_RST = 10'd1021;
	localparam logic [LIMIT_W-1:0]       ERROR_LIMIT_RST = 8'd5;
	localparam logic [CNT_W-1:0]         COUNT_MAX       = 8'd255;

	localparam logic [1:0] MODE_BYTE    = 2'd0;
	localparam logic [1:0] MODE_VERDICT = 2'd1;
	localparam logic [1:0] MODE_RX_ERR  = 2'd2;
	localparam logic [1:0] MODE_RX_OK   = 2'd3;

	localparam logic [1:0] PH_HEADER  = 2'd0;
	localparam logic [1:0] PH_LEN_HI  = 2'd1;
	localparam logic [1:0] PH_LEN_LO  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	typedef struct packed {
		logic [1:0]       phase;
		logic [7:0]       header;
		logic [7:0]       len_hi;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] remaining;
		logic [POS_W-1:0] position;
	} frm_t;

	typedef struct packed {
		logic rx_inc;
		logic rx_clr;
		logic pe_inc;
		logic pe_clr;
	} err_req_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic [POS_W-1:0] byte_position;
		logic             frame_end;
		logic             length_error;
	} beat_res_t;

endpackage

/* hdl/lpfr_err_ctr.sv */
module lpfr_err_ctr
	import lpfr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  logic               inc,
	input  logic               clr,
	input  logic [LIMIT_W-1:0] limit,
	output logic [CNT_W-1:0]   count_d,
	output logic               trip
);

	logic [CNT_W-1:0] count_q;

	always_comb begin
		count_d = count_q;
		if (clr) begin
			count_d = '0;
		end else if (inc && count_q != COUNT_MAX) begin
			count_d = count_q + CNT_W'(1);
		end
	end

	assign trip = en && inc && (count_d >= limit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= count_d;
		end
	end

endmodule

/* hdl/lpfr_step.sv */
module lpfr_step
	import lpfr_pkg::*;
#(
	parameter int FrameBufferBytes = FRAME_BUFFER_BYTES_DEF
) (
	input  logic                     active,
	input  logic [1:0]               mode,
	input  logic [7:0]               in_byte,
	input  logic                     decode_ok,
	input  logic [MAX_PAYLOAD_W-1:0] max_payload,
	input  frm_t                     frm_q,
	output frm_t                     frm_d,
	output beat_res_t                res,
	output err_req_t                 req
);

	localparam logic [LEN_W:0] BufLimit = (LEN_W+1)'(FrameBufferBytes - 3);

	logic [LEN_W-1:0] new_len;
	logic             len_ok;
	logic [LEN_W-1:0] rem_dec;

	assign new_len = {frm_q.len_hi, in_byte};
	assign len_ok  = (new_len <= LEN_W'(max_payload)) && ({1'b0, new_len} <= BufLimit);
	assign rem_dec = frm_q.remaining - LEN_W'(1);

	always_comb begin
		frm_d = frm_q;
		res   = '0;
		req   = '0;
		if (active) begin
			case (mode)
				MODE_BYTE: begin
					res.out_byte   = in_byte;
					res.byte_valid = 1'b1;
					case (frm_q.phase)
						PH_HEADER: begin
							frm_d.header   = in_byte;
							frm_d.len      = '0;
							frm_d.position = '0;
							frm_d.phase    = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							frm_d.len_hi   = in_byte;
							frm_d.position = POS_W'(1);
							frm_d.phase    = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							frm_d.len      = new_len;
							frm_d.position = POS_W'(2);
							if (new_len == '0) begin
								res.frame_end = 1'b1;
								frm_d.phase   = PH_HEADER;
							end else if (!len_ok) begin
								res.length_error = 1'b1;
								req.pe_inc       = 1'b1;
								frm_d.phase      = PH_HEADER;
							end else begin
								frm_d.remaining = new_len;
								frm_d.phase     = PH_PAYLOAD;
							end
						end
						default: begin
							frm_d.position  = frm_q.position + POS_W'(1);
							frm_d.remaining = rem_dec;
							if (rem_dec == '0) begin
								res.frame_end = 1'b1;
								frm_d.phase   = PH_HEADER;
							end
						end
					endcase
					res.byte_position = frm_d.position;
				end
				MODE_VERDICT: begin
					req.pe_clr = decode_ok;
					req.pe_inc = !decode_ok;
				end
				MODE_RX_ERR: begin
					req.rx_inc = 1'b1;
				end
				default: begin
					req.rx_clr = 1'b1;
				end
			endcase
		end
	end

endmodule

/* hdl/length_prefixed_frame_receiver.sv */
// the result beat is registered and shown in the cycle after its input beat is accepted
// throughput: one item per cycle while the output is not stalled; the single result register sets the rate
// each item is parsed in one pass between the frame state and the result register
// reset: arst_n clears frame state, error counters, fail-stop and the output valid,
// and loads the register defaults (max_payload 1021, both error limits 5)
module length_prefixed_frame_receiver
	import lpfr_pkg::*;
#(
	parameter int FrameBufferBytes = FRAME_BUFFER_BYTES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// in_byte[7:0], decode_ok[8], zero[15:9]
	input  logic [IN_DATA_W-1:0]   s_axis_tdata,
	// mode[1:0]
	input  logic [1:0]             s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_byte[7:0], byte_position[17:8], header_value[25:18], payload_length[41:26],
	// length_error[42], rx_errors[50:43], parse_errors[58:51], fail_stop[59], zero[63:60]
	output logic [OUT_DATA_W-1:0]  m_axis_tdata,
	// byte_valid[0]
	output logic                   m_axis_tuser,
	// frame_end
	output logic                   m_axis_tlast
);

	logic [MAX_PAYLOAD_W-1:0] max_payload_q;
	logic [LIMIT_W-1:0]       rx_limit_q;
	logic [LIMIT_W-1:0]       pe_limit_q;

	frm_t      frm_q, frm_d;
	beat_res_t res;
	err_req_t  req;
	logic      stopped_q, stopped_d;
	logic      accept, active;
	logic [CNT_W-1:0] rx_cnt_d, pe_cnt_d;
	logic      rx_trip, pe_trip;
	logic      m_valid_q;
	logic [OUT_DATA_W-1:0] tdata_q;
	logic      tuser_q, tlast_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_payload_q <= MAX_PAYLOAD_RST;
			rx_limit_q    <= ERROR_LIMIT_RST;
			pe_limit_q    <= ERROR_LIMIT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MAX_PAYLOAD:       max_payload_q <= cfg_data;
				REG_RX_ERROR_LIMIT:    rx_limit_q    <= cfg_data[LIMIT_W-1:0];
				REG_PARSE_ERROR_LIMIT: pe_limit_q    <= cfg_data[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	assign s_axis_tready = !m_valid_q || m_axis_tready;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign active        = accept && !stopped_q;

	lpfr_step #(
		.FrameBufferBytes(FrameBufferBytes)
	) u_step (
		.active     (active),
		.mode       (s_axis_tuser),
		.in_byte    (s_axis_tdata[7:0]),
		.decode_ok  (s_axis_tdata[8]),
		.max_payload(max_payload_q),
		.frm_q      (frm_q),
		.frm_d      (frm_d),
		.res        (res),
		.req        (req)
	);

	lpfr_err_ctr u_rx_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (active),
		.inc    (req.rx_inc),
		.clr    (req.rx_clr),
		.limit  (rx_limit_q),
		.count_d(rx_cnt_d),
		.trip   (rx_trip)
	);

	lpfr_err_ctr u_pe_ctr (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (active),
		.inc    (req.pe_inc),
		.clr    (req.pe_clr),
		.limit  (pe_limit_q),
		.count_d(pe_cnt_d),
		.trip   (pe_trip)
	);

	assign stopped_d = stopped_q || rx_trip || pe_trip;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frm_q     <= '0;
			stopped_q <= 1'b0;
		end else if (active) begin
			frm_q     <= frm_d;
			stopped_q <= stopped_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (accept) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tdata_q <= {4'b0, stopped_d, pe_cnt_d, rx_cnt_d, res.length_error,
				frm_d.len, frm_d.header, res.byte_position, res.out_byte};
			tuser_q <= res.byte_valid;
			tlast_q <= res.frame_end;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = tdata_q;
	assign m_axis_tuser  = tuser_q;
	assign m_axis_tlast  = tlast_q;

	a_stop_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(stopped_q))
		else $error("fail-stop cleared");

	a_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |=> $stable(frm_q))
		else $error("frame state moved after fail-stop");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_valid_q |-> s_axis_tready)
		else $error("input stalled with empty result register");

	a_last_is_byte: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
		else $error("frame end on a non-byte result");

endmodule

/* bench/tb_length_prefixed_frame_receiver.sv */
module tb_length_prefixed_frame_receiver
	import lpfr_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_REPORTS  = 10;
	localparam int BUF_LIMIT    = FRAME_BUFFER_BYTES_DEF - 3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       ok;
	} rx_item_t;

	typedef struct packed {
		logic [7:0]       out_byte;
		logic             byte_valid;
		logic [POS_W-1:0] byte_position;
		logic             frame_end;
		logic [7:0]       header_value;
		logic [LEN_W-1:0] payload_length;
		logic             length_error;
		logic [CNT_W-1:0] rx_errors;
		logic [CNT_W-1:0] parse_errors;
		logic             fail_stop;
	} frame_beat_t;

	typedef struct packed {
		logic [1:0]       phase;
		logic [7:0]       header;
		logic [7:0]       len_hi;
		logic [LEN_W-1:0] len;
		logic [LEN_W-1:0] left;
		logic [POS_W-1:0] pos;
		logic [CNT_W-1:0] rx_cnt;
		logic [CNT_W-1:0] pe_cnt;
		logic             halted;
	} rx_state_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_DATA_W-1:0]   s_axis_tdata;
	logic [1:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_DATA_W-1:0]  m_axis_tdata;
	logic                   m_axis_tuser;
	logic                   m_axis_tlast;

	rx_state_t         rx_model;
	logic [9:0]        max_payload_cfg;
	logic [7:0]        rx_limit_cfg;
	logic [7:0]        pe_limit_cfg;
	frame_beat_t       pending_beats[$];
	int                mismatches = 0;
	int                items_sent = 0;
	int                cycle_count = 0;
	bit                burst = 1'b0;
	bit                hold_req = 1'b0;

	length_prefixed_frame_receiver DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	function automatic logic [CNT_W-1:0] bumped(input logic [CNT_W-1:0] c);
		return (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic frame_beat_t parse_step(inout rx_state_t s, input rx_item_t it);
		frame_beat_t r;
		logic [LEN_W-1:0] len;
		r = '0;
		if (!s.halted) begin
			case (it.mode)
				MODE_BYTE: begin
					r.out_byte   = it.data;
					r.byte_valid = 1'b1;
					case (s.phase)
						PH_HEADER: begin
							s.header = it.data;
							s.len    = '0;
							s.pos    = '0;
							s.phase  = PH_LEN_HI;
						end
						PH_LEN_HI: begin
							s.len_hi = it.data;
							s.pos    = 10'd1;
							s.phase  = PH_LEN_LO;
						end
						PH_LEN_LO: begin
							len   = {s.len_hi, it.data};
							s.len = len;
							s.pos = 10'd2;
							if (len == 0) begin
								r.frame_end = 1'b1;
								s.phase     = PH_HEADER;
							end else if (len > LEN_W'(max_payload_cfg) ||
									len > LEN_W'(BUF_LIMIT)) begin
								r.length_error = 1'b1;
								s.phase        = PH_HEADER;
								s.pe_cnt       = bumped(s.pe_cnt);
								if (s.pe_cnt >= pe_limit_cfg)
									s.halted = 1'b1;
							end else begin
								s.left  = len;
								s.phase = PH_PAYLOAD;
							end
						end
						default: begin
							s.pos  = s.pos + 1'b1;
							s.left = s.left - 1'b1;
							if (s.left == 0) begin
								r.frame_end = 1'b1;
								s.phase     = PH_HEADER;
							end
						end
					endcase
					r.byte_position = s.pos;
				end
				MODE_VERDICT: begin
					if (it.ok) begin
						s.pe_cnt = '0;
					end else begin
						s.pe_cnt = bumped(s.pe_cnt);
						if (s.pe_cnt >= pe_limit_cfg)
							s.halted = 1'b1;
					end
				end
				MODE_RX_ERR: begin
					s.rx_cnt = bumped(s.rx_cnt);
					if (s.rx_cnt >= rx_limit_cfg)
						s.halted = 1'b1;
				end
				default: s.rx_cnt = '0;
			endcase
		end
		r.header_value   = s.header;
		r.payload_length = s.len;
		r.rx_errors      = s.rx_cnt;
		r.parse_errors   = s.pe_cnt;
		r.fail_stop      = s.halted;
		return r;
	endfunction

	function automatic string beat_str(input frame_beat_t b);
		return $sformatf("byte %h valid %b pos %0d end %b hdr %h len %h lerr %b rx %0d pe %0d stop %b",
			b.out_byte, b.byte_valid, b.byte_position, b.frame_end, b.header_value,
			b.payload_length, b.length_error, b.rx_errors, b.parse_errors, b.fail_stop);
	endfunction

	always @(posedge clk) begin
		frame_beat_t got;
		frame_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.out_byte       = m_axis_tdata[7:0];
			got.byte_valid     = m_axis_tuser;
			got.byte_position  = m_axis_tdata[17:8];
			got.frame_end      = m_axis_tlast;
			got.header_value   = m_axis_tdata[25:18];
			got.payload_length = m_axis_tdata[41:26];
			got.length_error   = m_axis_tdata[42];
			got.rx_errors      = m_axis_tdata[50:43];
			got.parse_errors   = m_axis_tdata[58:51];
			got.fail_stop      = m_axis_tdata[59];
			if (pending_beats.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected beat at cycle %0d: %s", cycle_count, beat_str(got));
			end else begin
				want = pending_beats.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS) begin
						$display("mismatch at cycle %0d", cycle_count);
						$display("  expected %s", beat_str(want));
						$display("  actual   %s", beat_str(got));
					end
				end
			end
		end
	end

	function automatic int draw_gap();
		if (burst)
			return 0;
		return $urandom_range(0, 14);
	endfunction

	// receiver: random stalls per beat, plus one long hold-off on request
	initial begin
		int gap;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			gap = draw_gap();
			if (gap > 0) begin
				m_axis_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	function automatic rx_item_t byte_item(input logic [7:0] b);
		rx_item_t it;
		it.mode = MODE_BYTE;
		it.data = b;
		it.ok   = 1'($urandom_range(0, 1));
		return it;
	endfunction

	function automatic rx_item_t ctrl_item(input logic [1:0] mode, input logic ok);
		rx_item_t it;
		it.mode = mode;
		it.data = 8'($urandom_range(0, 255));
		it.ok   = ok;
		return it;
	endfunction

	// entered and left at a falling edge
	task automatic send_item(input rx_item_t it);
		int gap;
		frame_beat_t beat;
		gap = draw_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tdata  <= {7'd0, it.ok, it.data};
		s_axis_tuser  <= it.mode;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		beat = parse_step(rx_model, it);
		pending_beats.push_back(beat);
		items_sent++;
		@(negedge clk);
	endtask

	// clears the counter first when this beat would otherwise trip fail-stop
	task automatic safe_send(input rx_item_t it);
		rx_state_t trial;
		trial = rx_model;
		void'(parse_step(trial, it));
		if (trial.halted && !rx_model.halted) begin
			if (trial.pe_cnt != rx_model.pe_cnt)
				send_item(ctrl_item(MODE_VERDICT, 1'b1));
			else
				send_item(ctrl_item(MODE_RX_OK, 1'($urandom_range(0, 1))));
		end
		send_item(it);
	endtask

	task automatic maybe_ctrl(input int pct);
		if ($urandom_range(0, 99) < pct)
			safe_send(ctrl_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1))));
	endtask

	task automatic send_frame(input logic [7:0] hdr, input logic [15:0] len, input int pct);
		safe_send(byte_item(hdr));
		maybe_ctrl(pct);
		safe_send(byte_item(len[15:8]));
		maybe_ctrl(pct);
		safe_send(byte_item(len[7:0]));
		while (rx_model.phase == PH_PAYLOAD && !rx_model.halted) begin
			maybe_ctrl(pct);
			safe_send(byte_item(8'($urandom_range(0, 255))));
		end
	endtask

	// finish whatever frame noise has opened, keeping its length short
	task automatic resync_frame();
		while (rx_model.phase != PH_HEADER) begin
			case (rx_model.phase)
				PH_LEN_HI: safe_send(byte_item(8'h00));
				PH_LEN_LO: safe_send(byte_item(8'($urandom_range(0, 8))));
				default:   safe_send(byte_item(8'($urandom_range(0, 255))));
			endcase
		end
	endtask

	function automatic logic [15:0] pick_length();
		int c;
		int mx;
		int top;
		c   = $urandom_range(0, 9);
		mx  = int'(max_payload_cfg);
		top = (mx < 12) ? mx : 12;
		if (c <= 5)
			return 16'($urandom_range(0, top));
		if (c == 6)
			return (mx <= 40) ? 16'($urandom_range(mx - 1, mx + 1)) :
				16'($urandom_range(0, top));
		if (c <= 8)
			return 16'($urandom_range(mx + 1, 65535));
		return 16'(mx + 1);
	endfunction

	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_config(input logic [9:0] mx, input logic [7:0] rx, input logic [7:0] pe);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MAX_PAYLOAD;
		cfg_data  <= mx;
		@(negedge clk);
		cfg_index <= REG_RX_ERROR_LIMIT;
		cfg_data  <= {2'b00, rx};
		@(negedge clk);
		cfg_index <= REG_PARSE_ERROR_LIMIT;
		cfg_data  <= {2'b00, pe};
		@(negedge clk);
		cfg_we          <= 1'b0;
		max_payload_cfg  = mx;
		rx_limit_cfg     = rx;
		pe_limit_cfg     = pe;
	endtask

	task automatic test_directed();
		send_frame(8'hFF, 16'h0000, 0);
		send_frame(8'h00, 16'h0001, 0);
		send_frame(8'h5A, 16'h0002, 0);
		send_frame(8'hC3, 16'hFFFF, 0);
		safe_send(ctrl_item(MODE_VERDICT, 1'b0));
		safe_send(ctrl_item(MODE_VERDICT, 1'b1));
		// non-byte items in the middle of a frame leave it intact
		safe_send(byte_item(8'h81));
		safe_send(byte_item(8'h00));
		safe_send(ctrl_item(MODE_RX_ERR, 1'b0));
		safe_send(byte_item(8'h02));
		safe_send(ctrl_item(MODE_VERDICT, 1'b0));
		safe_send(byte_item(8'h80));
		safe_send(ctrl_item(MODE_RX_OK, 1'b1));
		safe_send(byte_item(8'h7F));
	endtask

	task automatic test_longest_frame();
		drain_block();
		write_config(10'd150, 8'd5, 8'd5);
		send_frame(8'($urandom_range(0, 255)), 16'd150, 0);
		send_frame(8'($urandom_range(0, 255)), 16'd151, 0);
	endtask

	task automatic test_random_traffic(input int count, input logic [9:0] mx,
			input logic [7:0] rx, input logic [7:0] pe);
		int start;
		int r;
		int n;
		drain_block();
		write_config(mx, rx, pe);
		start = items_sent;
		while (items_sent - start < count) begin
			if ($urandom_range(0, 29) == 0)
				burst = !burst;
			r = $urandom_range(0, 99);
			if (r < 65) begin
				resync_frame();
				send_frame(8'($urandom_range(0, 255)), pick_length(), 8);
			end else if (r < 80) begin
				n = $urandom_range(1, 3);
				repeat (n) safe_send(byte_item(8'($urandom_range(0, 255))));
			end else if (r < 90) begin
				resync_frame();
				send_frame(8'($urandom_range(0, 255)), pick_length(), 40);
			end else begin
				n = $urandom_range(1, 3);
				repeat (n) safe_send(ctrl_item(2'($urandom_range(1, 3)),
					1'($urandom_range(0, 1))));
			end
		end
		burst = 1'b0;
	endtask

	// output held off while the sender keeps offering beats back to back
	task automatic test_backpressure();
		int start;
		drain_block();
		resync_frame();
		hold_req = 1'b1;
		burst    = 1'b1;
		start    = items_sent;
		while (items_sent - start < 40)
			send_frame(8'($urandom_range(0, 255)), 16'($urandom_range(0, 6)), 10);
		burst = 1'b0;
	endtask

	task automatic test_fail_stop();
		drain_block();
		write_config(max_payload_cfg, 8'd40, 8'd255);
		safe_send(ctrl_item(MODE_RX_OK, 1'b0));
		safe_send(ctrl_item(MODE_VERDICT, 1'b1));
		repeat (39) send_item(ctrl_item(MODE_RX_ERR, 1'($urandom_range(0, 1))));
		drain_block();
		write_config(max_payload_cfg, 8'd40, 8'd1);
		send_item(ctrl_item(MODE_VERDICT, 1'b0));
		repeat (30) begin
			if ($urandom_range(0, 1))
				send_item(byte_item(8'($urandom_range(0, 255))));
			else
				send_item(ctrl_item(2'($urandom_range(1, 3)), 1'($urandom_range(0, 1))));
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = REG_MAX_PAYLOAD;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = MODE_BYTE;
		rx_model        = '0;
		rx_model.phase  = PH_HEADER;
		max_payload_cfg = MAX_PAYLOAD_RST;
		rx_limit_cfg    = ERROR_LIMIT_RST;
		pe_limit_cfg    = ERROR_LIMIT_RST;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed();
		test_longest_frame();
		test_random_traffic(110, 10'd1, 8'd255, 8'd255);
		test_random_traffic(110, 10'd1021, 8'd2, 8'd3);
		test_backpressure();
		test_random_traffic(110, 10'd24, 8'd7, 8'd2);
		test_random_traffic(110, 10'($urandom_range(1, 1021)), 8'($urandom_range(2, 255)),
			8'($urandom_range(2, 255)));
		test_random_traffic(110, 10'($urandom_range(1, 40)), 8'($urandom_range(2, 255)),
			8'($urandom_range(2, 255)));
		test_fail_stop();

		drain_block();
		if (mismatches == 0 && pending_beats.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
